// ===== rtl/core/abcrs_pkg.sv =====
`timescale 1ns / 1ps

package abcrs_pkg;

  // Register reset values.
  localparam logic [31:0] RecordMagicRst    = 32'h5243_4647;
  localparam logic [31:0] CurrentVersionRst = 32'h0000_0002;
  localparam logic [31:0] LegacyVersionRst  = 32'h0000_0001;
  localparam logic [31:0] ChecksumSaltRst   = 32'ha5c3_5a3c;

  // Last usable sequence number.
  localparam logic [31:0] SeqLast = 32'hffff_ffff;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RECORD_MAGIC    = 2'd0;
  localparam logic [1:0] CFG_CURRENT_VERSION = 2'd1;
  localparam logic [1:0] CFG_LEGACY_VERSION  = 2'd2;
  localparam logic [1:0] CFG_CHECKSUM_SALT   = 2'd3;

  // Item kinds.
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  // Record slots.
  localparam logic [1:0] SLOT_PRIMARY = 2'd0;
  localparam logic [1:0] SLOT_BACKUP  = 2'd1;
  localparam logic [1:0] SLOT_LEGACY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
  localparam logic [1:0] ST_NONE_VALID = 2'd3;

  // Which kept record is selected.
  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,
    SEL_PRIMARY = 2'd1,
    SEL_BACKUP  = 2'd2,
    SEL_LEGACY  = 2'd3
  } sel_t;

  typedef struct packed {
    logic [31:0] record_magic;
    logic [31:0] current_version;
    logic [31:0] legacy_version;
    logic [31:0] checksum_salt;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        first;
    logic [1:0]  slot;
    logic [31:0] rec_magic;
    logic [31:0] rec_version;
    logic [31:0] rec_on_level;
    logic [31:0] rec_off_level;
    logic [31:0] rec_delay;
    logic [31:0] rec_limit;
    logic [31:0] rec_sequence;
    logic [31:0] rec_check;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic        chosen_slot;
    logic        from_legacy;
    logic [31:0] sel_on_level;
    logic [31:0] sel_off_level;
    logic [31:0] sel_delay;
    logic [31:0] sel_limit;
    logic [31:0] sel_sequence;
    logic [31:0] new_check;
    logic        target_slot;
  } out_t;

  // Level and timing values of one record.
  typedef struct packed {
    logic [31:0] on_level;
    logic [31:0] off_level;
    logic [31:0] delay;
    logic [31:0] limit;
  } lvl_t;

  // A kept primary or backup record.
  typedef struct packed {
    lvl_t        lvl;
    logic [31:0] seq;
  } rec_t;

  // Validation flags of the current item.
  typedef struct packed {
    logic slot_good;
    logic legacy_good;
    logic vals_ok;
  } chk_t;

  // Kept records as seen by the selector.
  typedef struct packed {
    logic pri_ok;
    logic bak_ok;
    logic leg_ok;
    rec_t pri;
    rec_t bak;
    lvl_t leg;
  } kept_t;

endpackage

// ===== rtl/core/abcrs_check.sv =====
`timescale 1ns / 1ps

module abcrs_check (
  input  abcrs_pkg::in_t  item,
  input  abcrs_pkg::cfg_t cfg,
  output abcrs_pkg::chk_t chk
);
  import abcrs_pkg::*;

  logic [31:0] xsum;
  logic        magic_ok;

  // XOR of the record words and the salt, without sequence and check word.
  assign xsum = item.rec_magic ^ item.rec_version ^ item.rec_on_level ^
                item.rec_off_level ^ item.rec_delay ^ item.rec_limit ^
                cfg.checksum_salt;

  assign magic_ok = item.rec_magic == cfg.record_magic;

  // Levels must be ordered and the delay must fit in the timeout.
  assign chk.vals_ok = (item.rec_on_level > item.rec_off_level) &&
                       (item.rec_delay <= item.rec_limit);

  // Slot records carry the sequence inside the check word; legacy ones do not.
  assign chk.slot_good = magic_ok && (item.rec_version == cfg.current_version) &&
                         (item.rec_check == (xsum ^ item.rec_sequence)) && chk.vals_ok;
  assign chk.legacy_good = magic_ok && (item.rec_version == cfg.legacy_version) &&
                           (item.rec_check == xsum) && chk.vals_ok;

endmodule

// ===== rtl/core/abcrs_select.sv =====
`timescale 1ns / 1ps

module abcrs_select (
  input  abcrs_pkg::in_t   item,
  input  abcrs_pkg::cfg_t  cfg,
  input  abcrs_pkg::kept_t kept,
  input  abcrs_pkg::chk_t  chk,
  input  logic             good,
  output abcrs_pkg::out_t  res
);
  import abcrs_pkg::*;

  sel_t        sel;
  lvl_t        sel_lvl;
  logic [31:0] sel_seq;
  logic        slot_sel;
  logic [31:0] next_seq;

  // Primary wins ties; legacy only when neither slot record is kept.
  always_comb begin
    if (kept.pri_ok && (!kept.bak_ok || (kept.pri.seq >= kept.bak.seq))) begin
      sel = SEL_PRIMARY;
    end else if (kept.bak_ok) begin
      sel = SEL_BACKUP;
    end else if (kept.leg_ok) begin
      sel = SEL_LEGACY;
    end else begin
      sel = SEL_NONE;
    end
  end

  // Values of the selected record.
  always_comb begin
    case (sel)
      SEL_PRIMARY: begin
        sel_lvl = kept.pri.lvl;
        sel_seq = kept.pri.seq;
      end
      SEL_BACKUP: begin
        sel_lvl = kept.bak.lvl;
        sel_seq = kept.bak.seq;
      end
      SEL_LEGACY: begin
        sel_lvl = kept.leg;
        sel_seq = '0;
      end
      default: begin
        sel_lvl = '0;
        sel_seq = '0;
      end
    endcase
  end

  assign slot_sel = (sel == SEL_PRIMARY) || (sel == SEL_BACKUP);
  assign next_seq = slot_sel ? (sel_seq + 32'd1) : 32'd1;

  // Result beat for an offer or a build.
  always_comb begin
    res               = '0;
    res.found         = sel != SEL_NONE;
    res.chosen_slot   = sel == SEL_BACKUP;
    res.from_legacy   = sel == SEL_LEGACY;
    res.sel_on_level  = sel_lvl.on_level;
    res.sel_off_level = sel_lvl.off_level;
    res.sel_delay     = sel_lvl.delay;
    res.sel_limit     = sel_lvl.limit;
    if (item.kind == KIND_OFFER) begin
      res.sel_sequence = sel_seq;
      if (good) begin
        res.status = ST_OK;
      end else if (sel != SEL_NONE) begin
        res.status = ST_INVALID;
      end else begin
        res.status = ST_NONE_VALID;
      end
    end else if (!chk.vals_ok) begin
      res.status = ST_INVALID;
    end else if (slot_sel && (sel_seq == SeqLast)) begin
      res.status = ST_EXHAUSTED;
    end else begin
      res.status       = ST_OK;
      res.sel_sequence = next_seq;
      res.target_slot  = (sel == SEL_PRIMARY) || (sel == SEL_LEGACY);
      res.new_check    = cfg.record_magic ^ cfg.current_version ^ item.rec_on_level ^
                         item.rec_off_level ^ item.rec_delay ^ item.rec_limit ^
                         next_seq ^ cfg.checksum_salt;
    end
  end

endmodule

// ===== rtl/core/ab_config_record_selector_core.sv =====
`timescale 1ns / 1ps
// A result beat passes the input register, then the result register; the input stage
// waits while the result register holds a stalled beat.
// Throughput: one item per cycle unless stalled; kept records update with the result.
// Reset clears the handshake state and the record valid bits and loads the
// register defaults; kept record values are not cleared.

module ab_config_record_selector_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  abcrs_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output abcrs_pkg::out_t  out_data
);
  import abcrs_pkg::*;

  cfg_t  cfg_r;
  in_t   in_r;
  logic  in_valid_r;
  out_t  out_r;
  logic  out_valid_r;

  logic  pri_ok_r, bak_ok_r, leg_ok_r;
  logic  pri_ok_nxt, bak_ok_nxt, leg_ok_nxt;
  rec_t  pri_r, bak_r, pri_nxt, bak_nxt;
  lvl_t  leg_r, leg_nxt;

  chk_t  chk;
  kept_t kept;
  out_t  res;
  logic  good;
  logic  can_load;
  logic  fire;
  rec_t  item_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_magic    <= RecordMagicRst;
      cfg_r.current_version <= CurrentVersionRst;
      cfg_r.legacy_version  <= LegacyVersionRst;
      cfg_r.checksum_salt   <= ChecksumSaltRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RECORD_MAGIC:    cfg_r.record_magic    <= cfg_wdata;
        CFG_CURRENT_VERSION: cfg_r.current_version <= cfg_wdata;
        CFG_LEGACY_VERSION:  cfg_r.legacy_version  <= cfg_wdata;
        CFG_CHECKSUM_SALT:   cfg_r.checksum_salt   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free.
  assign can_load = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && can_load;
  assign in_stall = in_valid_r && !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  abcrs_check u_check (
    .item (in_r),
    .cfg  (cfg_r),
    .chk  (chk)
  );

  assign item_rec.lvl.on_level  = in_r.rec_on_level;
  assign item_rec.lvl.off_level = in_r.rec_off_level;
  assign item_rec.lvl.delay     = in_r.rec_delay;
  assign item_rec.lvl.limit     = in_r.rec_limit;
  assign item_rec.seq           = in_r.rec_sequence;

  // Kept records after this item: first clears, an offer updates its slot.
  always_comb begin
    pri_ok_nxt = pri_ok_r && !in_r.first;
    bak_ok_nxt = bak_ok_r && !in_r.first;
    leg_ok_nxt = leg_ok_r && !in_r.first;
    pri_nxt    = pri_r;
    bak_nxt    = bak_r;
    leg_nxt    = leg_r;
    good       = 1'b0;
    if (in_r.kind == KIND_OFFER) begin
      case (in_r.slot)
        SLOT_PRIMARY: begin
          good       = chk.slot_good;
          pri_ok_nxt = chk.slot_good;
          if (chk.slot_good) begin
            pri_nxt = item_rec;
          end
        end
        SLOT_BACKUP: begin
          good       = chk.slot_good;
          bak_ok_nxt = chk.slot_good;
          if (chk.slot_good) begin
            bak_nxt = item_rec;
          end
        end
        SLOT_LEGACY: begin
          good       = chk.legacy_good;
          leg_ok_nxt = chk.legacy_good;
          if (chk.legacy_good) begin
            leg_nxt = item_rec.lvl;
          end
        end
        default: ;
      endcase
    end
  end

  assign kept.pri_ok = pri_ok_nxt;
  assign kept.bak_ok = bak_ok_nxt;
  assign kept.leg_ok = leg_ok_nxt;
  assign kept.pri    = pri_nxt;
  assign kept.bak    = bak_nxt;
  assign kept.leg    = leg_nxt;

  abcrs_select u_select (
    .item (in_r),
    .cfg  (cfg_r),
    .kept (kept),
    .chk  (chk),
    .good (good),
    .res  (res)
  );

  // Record valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_ok_r <= 1'b0;
      bak_ok_r <= 1'b0;
      leg_ok_r <= 1'b0;
    end else if (fire) begin
      pri_ok_r <= pri_ok_nxt;
      bak_ok_r <= bak_ok_nxt;
      leg_ok_r <= leg_ok_nxt;
    end
  end

  // Record values, read only while their valid bit is set.
  always_ff @(posedge clk) begin
    if (fire) begin
      pri_r <= pri_nxt;
      bak_r <= bak_nxt;
      leg_r <= leg_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An item in the input stage always reaches the result register next.
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted item did not reach the result register");

  // Backup and legacy selections exclude each other.
  a_sel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.chosen_slot && out_r.from_legacy))
    else $error("backup and legacy both flagged as selected");

  // Without a selection neither slot flag may be set.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (!out_r.chosen_slot && !out_r.from_legacy))
    else $error("slot flags set while nothing is selected");

  // An exhausted sequence comes only from a selected primary or backup record.
  a_exhaust_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_EXHAUSTED)) |->
      (out_r.found && !out_r.from_legacy && (out_r.new_check == 32'd0)))
    else $error("exhausted status without a slot selection");

endmodule
